/* rtl/core/fft_pkg.sv */
// shared constants, types and twiddle table for the radix-2 fft core
package fft_pkg;

  localparam int MAX_LOG2_POINTS = 10;
  localparam int TWIDDLE_BITS    = 16;

  localparam int FRAC_BITS  = TWIDDLE_BITS - 1;
  localparam int MAX_POINTS = 1 << MAX_LOG2_POINTS;
  localparam int TW_COUNT   = 1 << (MAX_LOG2_POINTS - 1);
  localparam int TWI_W      = (MAX_LOG2_POINTS > 1) ? MAX_LOG2_POINTS - 1 : 1;
  localparam int OCT_COUNT  = TW_COUNT / 4 + 1;
  localparam int OCT_W      = $clog2(OCT_COUNT);
  localparam int LOG2_W     = $clog2(MAX_LOG2_POINTS + 1);
  localparam int LG_RESET   = (MAX_LOG2_POINTS < 10) ? MAX_LOG2_POINTS : 10;

  localparam int SAMPLE_W = 16;
  localparam int DATA_W   = 32;
  localparam int CFG_W    = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_LOG2_POINTS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_MODE = 1'd1;

  localparam logic [63:0] Q30_ONE   = 64'd1 << 30;
  localparam logic [63:0] PI_Q30    = 64'd3373259426;
  localparam logic [31:0] HALF_TURN = 32'd65536;

  // first octant only, each entry holds {cos, sin}, both signed Q1.FRAC_BITS
  typedef logic [2*TWIDDLE_BITS-1:0] tw_table_t [OCT_COUNT];

  function automatic logic [TWIDDLE_BITS-1:0] q30_to_tw(logic [63:0] q);
    logic [63:0] v;
    logic [63:0] lim;
    lim = (64'd1 << FRAC_BITS) - 64'd1;
    v = (q + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    if (v > lim) begin
      v = lim;
    end
    return v[TWIDDLE_BITS-1:0];
  endfunction

  // sin and cos in q30 of pi*r/65536, r within the first octant; returns {sin, cos}
  function automatic logic [127:0] octant_sincos(logic [63:0] r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    x  = (r * PI_Q30 + 64'd32768) >> 16;
    x2 = (x * x + (64'd1 << 29)) >> 30;
    t = Q30_ONE;
    t = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
    t = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
    t = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    s = (x * t) >> 30;
    t = Q30_ONE;
    t = Q30_ONE - ((x2 * t) >> 30) / 64'd132;
    t = Q30_ONE - ((x2 * t) >> 30) / 64'd90;
    t = Q30_ONE - ((x2 * t) >> 30) / 64'd56;
    t = Q30_ONE - ((x2 * t) >> 30) / 64'd30;
    t = Q30_ONE - ((x2 * t) >> 30) / 64'd12;
    t = Q30_ONE - ((x2 * t) >> 30) / 64'd2;
    return {s, t};
  endfunction

  function automatic logic [2*TWIDDLE_BITS-1:0] make_twiddle(int j);
    logic [31:0]  p;
    logic         neg_cos;
    logic [127:0] sc;
    logic [63:0]  s;
    logic [63:0]  c;
    logic [TWIDDLE_BITS-1:0] cv;
    p = 32'(j) << (17 - MAX_LOG2_POINTS);
    neg_cos = 1'b0;
    if (p > HALF_TURN / 2) begin
      p = HALF_TURN - p;
      neg_cos = 1'b1;
    end
    if (p > HALF_TURN / 4) begin
      sc = octant_sincos(64'(HALF_TURN / 2 - p));
      c = sc[127:64];
      s = sc[63:0];
    end else begin
      sc = octant_sincos(64'(p));
      s = sc[127:64];
      c = sc[63:0];
    end
    cv = q30_to_tw(c);
    if (neg_cos) begin
      cv = -cv;
    end
    return {cv, q30_to_tw(s)};
  endfunction

  function automatic tw_table_t build_tw_table();
    tw_table_t tab;
    for (int j = 0; j < OCT_COUNT; j++) begin
      tab[j] = make_twiddle(j);
    end
    return tab;
  endfunction

  localparam tw_table_t TW_TABLE = build_tw_table();

endpackage

/* rtl/core/radix2_complex_fft_core.sv */
// radix-2 decimation in time fft core with frame buffering and one shared butterfly unit
//
//  channel   signals                                   direction
//  in        in_valid_i, in_stall_o, sample_re/im_i    into core
//  res       res_valid_o, res_stall_i, out_*_o,        out of core
//            frame_end_o
//  cfg       cfg_we_i, cfg_index_i, cfg_data_i         into core, write only
//
// an ordinary sample passes through a ram read of the old bin, then the output register
// the last sample of a frame adds the transform: a bit-reversed copy of the frame,
// then (N/2)log2(N) butterflies one after another, and a scaling pass over all N bins in
// inverse mode; the shared multiplier and the single result ram port keep these steps serial
// reset is asynchronous and active low; both buffers hold no reset value
// in_stall_o is high while a transaction or the transform is in flight or the output register stays full
module radix2_complex_fft_core
  import fft_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [SAMPLE_W-1:0]  sample_re_i,
  input  logic signed [SAMPLE_W-1:0]  sample_im_i,
  output logic                        res_valid_o,
  input  logic                        res_stall_i,
  output logic                        out_valid_o,
  output logic signed [DATA_W-1:0]    out_re_o,
  output logic signed [DATA_W-1:0]    out_im_o,
  output logic                        frame_end_o,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_W-1:0]            cfg_data_i
);

  localparam int AW     = MAX_LOG2_POINTS;
  localparam int TW     = TWIDDLE_BITS;
  localparam int PROD_W = TW + DATA_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int T_W    = SUM_W - FRAC_BITS;
  localparam int A_W    = T_W + 1;
  localparam int TWQ    = TW_COUNT / 2;
  localparam int TWO    = TW_COUNT / 4;
  localparam logic [AW-1:0] ALL1 = '1;

  typedef enum logic [4:0] {
    ST_IDLE, ST_FETCH, ST_COPY, ST_COPY_END,
    ST_BF_RDA, ST_BF_RDB, ST_BF_LDB,
    ST_BF_MUL0, ST_BF_MUL1, ST_BF_MUL2, ST_BF_MUL3, ST_BF_RND,
    ST_BF_WRA, ST_BF_WRB, ST_SC_RD, ST_SC_WR
  } state_e;

  state_e                    state_q;
  logic [AW-1:0]             count_q;
  logic                      result_ready_q;
  logic [LOG2_W-1:0]         lg_q;
  logic                      inverse_q;
  logic                      frame_done_q;
  logic [AW-1:0]             cnt_q;
  logic [AW-1:0]             bi_q;
  logic [LOG2_W-1:0]         stage_q;
  logic                      pend_q;
  logic [AW-1:0]             pend_addr_q;
  logic                      res_valid_q;
  logic                      out_valid_q;
  logic [DATA_W-1:0]         out_re_q;
  logic [DATA_W-1:0]         out_im_q;
  logic                      frame_end_q;
  logic signed [TW-1:0]      wr_q;
  logic signed [TW-1:0]      wi_q;
  logic signed [DATA_W-1:0]  a_re_q;
  logic signed [DATA_W-1:0]  a_im_q;
  logic signed [DATA_W-1:0]  b_re_q;
  logic signed [DATA_W-1:0]  b_im_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [PROD_W-1:0]  acc_q;
  logic signed [T_W-1:0]     t_re_q;
  logic signed [T_W-1:0]     t_im_q;

  logic                      in_acc;
  logic [AW-1:0]             n_mask;
  logic [AW-1:0]             bf_m;
  logic [AW-1:0]             bf_k;
  logic [AW-1:0]             bf_b;
  logic [AW-1:0]             ti_full;
  logic [TWI_W:0]            tw_idx;
  logic [TWI_W:0]            tw_u;
  logic [TWI_W:0]            tw_v;
  logic                      tw_neg;
  logic                      tw_swap;
  logic [2*TW-1:0]           tw_entry;
  logic [TW-1:0]             tw_cos;
  logic [TW-1:0]             tw_sin;
  logic                      bf_last;
  logic                      stage_last;
  logic signed [TW-1:0]      mul_a;
  logic signed [DATA_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [SUM_W-1:0]   t_sum;
  logic signed [SUM_W-1:0]   t_rnd;
  logic signed [DATA_W:0]    sc_re;
  logic signed [DATA_W:0]    sc_im;
  logic signed [DATA_W:0]    sc_half;

  logic                      ld_we;
  logic [2*SAMPLE_W-1:0]     ld_rdata;
  logic                      rs_we;
  logic [AW-1:0]             rs_waddr;
  logic [2*DATA_W-1:0]       rs_wdata;
  logic [AW-1:0]             rs_raddr;
  logic [2*DATA_W-1:0]       rs_rdata;

  function automatic logic [AW-1:0] bit_rev(logic [AW-1:0] v, logic [LOG2_W-1:0] lg);
    logic [AW-1:0] r;
    for (int i = 0; i < AW; i++) begin
      r[AW-1-i] = v[i];
    end
    return r >> (LOG2_W'(AW) - lg);
  endfunction

  function automatic logic [DATA_W-1:0] sat32(logic signed [A_W-1:0] v);
    logic signed [A_W-1:0] hi;
    logic signed [A_W-1:0] lo;
    hi = A_W'({1'b0, {(DATA_W-1){1'b1}}});
    lo = -hi - A_W'(1);
    if (v > hi) begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end else if (v < lo) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end
    return v[DATA_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] sext16(logic [SAMPLE_W-1:0] v);
    return {{(DATA_W-SAMPLE_W){v[SAMPLE_W-1]}}, v};
  endfunction

  assign in_stall_o = !((state_q == ST_IDLE) && (!res_valid_q || !res_stall_i));
  assign in_acc     = in_valid_i && !in_stall_o;
  assign n_mask     = ALL1 >> (LOG2_W'(AW) - lg_q);

  // butterfly addressing: group and offset within the current column
  assign bf_m       = bi_q & ~(ALL1 << stage_q);
  assign bf_k       = ((bi_q >> stage_q) << (stage_q + LOG2_W'(1))) | bf_m;
  assign bf_b       = bf_k | (AW'(1) << stage_q);
  assign ti_full    = bf_m << (LOG2_W'(AW - 1) - stage_q);

  // twiddle from the first octant table: past a quarter turn the cosine flips sign,
  // past an eighth turn sine and cosine trade places
  assign tw_idx     = {1'b0, ti_full[TWI_W-1:0]};
  assign tw_neg     = (tw_idx > (TWI_W+1)'(TWQ));
  assign tw_u       = tw_neg ? ((TWI_W+1)'(TW_COUNT) - tw_idx) : tw_idx;
  assign tw_swap    = (tw_u > (TWI_W+1)'(TWO));
  assign tw_v       = tw_swap ? ((TWI_W+1)'(TWQ) - tw_u) : tw_u;
  assign tw_entry   = TW_TABLE[tw_v[OCT_W-1:0]];
  assign tw_cos     = tw_swap ? tw_entry[TW-1:0] : tw_entry[2*TW-1:TW];
  assign tw_sin     = tw_swap ? tw_entry[2*TW-1:TW] : tw_entry[TW-1:0];

  assign bf_last    = (bi_q == (n_mask >> 1));
  assign stage_last = (stage_q == lg_q - LOG2_W'(1));

  always_comb begin
    case (state_q)
      ST_BF_MUL0: begin
        mul_a = wr_q;
        mul_b = b_re_q;
      end
      ST_BF_MUL1: begin
        mul_a = wi_q;
        mul_b = b_im_q;
      end
      ST_BF_MUL2: begin
        mul_a = wi_q;
        mul_b = b_re_q;
      end
      default: begin
        mul_a = wr_q;
        mul_b = b_im_q;
      end
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // real part subtracts, imaginary part adds
  assign t_sum = (state_q == ST_BF_MUL2) ? (SUM_W'(acc_q) - SUM_W'(prod_q))
                                         : (SUM_W'(acc_q) + SUM_W'(prod_q));
  assign t_rnd = (t_sum + (SUM_W'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;

  assign sc_half = (DATA_W+1)'(1) << (lg_q - LOG2_W'(1));
  assign sc_re = ((DATA_W+1)'($signed(rs_rdata[2*DATA_W-1:DATA_W])) + sc_half) >>> lg_q;
  assign sc_im = ((DATA_W+1)'($signed(rs_rdata[DATA_W-1:0])) + sc_half) >>> lg_q;

  assign ld_we = in_acc;

  always_comb begin
    rs_raddr = count_q;
    rs_we    = 1'b0;
    rs_waddr = pend_addr_q;
    rs_wdata = {sext16(ld_rdata[2*SAMPLE_W-1:SAMPLE_W]), sext16(ld_rdata[SAMPLE_W-1:0])};
    if (pend_q) begin
      rs_we = 1'b1;
    end
    case (state_q)
      ST_BF_RDA: rs_raddr = bf_k;
      ST_BF_RDB: rs_raddr = bf_b;
      ST_SC_RD:  rs_raddr = cnt_q;
      ST_BF_WRA: begin
        rs_we    = 1'b1;
        rs_waddr = bf_k;
        rs_wdata = {sat32(A_W'(a_re_q) + A_W'(t_re_q)), sat32(A_W'(a_im_q) + A_W'(t_im_q))};
      end
      ST_BF_WRB: begin
        rs_we    = 1'b1;
        rs_waddr = bf_b;
        rs_wdata = {sat32(A_W'(a_re_q) - A_W'(t_re_q)), sat32(A_W'(a_im_q) - A_W'(t_im_q))};
      end
      ST_SC_WR: begin
        rs_we    = 1'b1;
        rs_waddr = cnt_q;
        rs_wdata = {sc_re[DATA_W-1:0], sc_im[DATA_W-1:0]};
      end
      default: ;
    endcase
  end

  fft_ram #(
    .WIDTH (2 * SAMPLE_W),
    .DEPTH (MAX_POINTS)
  ) u_load_ram (
    .clk_i   (clk_i),
    .we_i    (ld_we),
    .waddr_i (count_q),
    .wdata_i ({sample_re_i, sample_im_i}),
    .raddr_i (cnt_q),
    .rdata_o (ld_rdata)
  );

  fft_ram #(
    .WIDTH (2 * DATA_W),
    .DEPTH (MAX_POINTS)
  ) u_result_ram (
    .clk_i   (clk_i),
    .we_i    (rs_we),
    .waddr_i (rs_waddr),
    .wdata_i (rs_wdata),
    .raddr_i (rs_raddr),
    .rdata_o (rs_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      count_q        <= '0;
      result_ready_q <= 1'b0;
      lg_q           <= LOG2_W'(LG_RESET);
      inverse_q      <= 1'b0;
      frame_done_q   <= 1'b0;
      cnt_q          <= '0;
      bi_q           <= '0;
      stage_q        <= '0;
      pend_q         <= 1'b0;
      pend_addr_q    <= '0;
      res_valid_q    <= 1'b0;
      out_valid_q    <= 1'b0;
      out_re_q       <= '0;
      out_im_q       <= '0;
      frame_end_q    <= 1'b0;
      wr_q           <= '0;
      wi_q           <= '0;
      a_re_q         <= '0;
      a_im_q         <= '0;
      b_re_q         <= '0;
      b_im_q         <= '0;
      prod_q         <= '0;
      acc_q          <= '0;
      t_re_q         <= '0;
      t_im_q         <= '0;
    end else begin
      pend_q <= 1'b0;
      if (res_valid_q && !res_stall_i) begin
        res_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_LOG2_POINTS: begin
            lg_q <= (cfg_data_i > CFG_W'(MAX_LOG2_POINTS)) ? LOG2_W'(MAX_LOG2_POINTS)
                                                           : LOG2_W'(cfg_data_i);
            count_q        <= '0;
            result_ready_q <= 1'b0;
          end
          CFG_INVERSE_MODE: inverse_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            frame_done_q <= (count_q == n_mask);
            count_q      <= (count_q == n_mask) ? '0 : count_q + AW'(1);
            state_q      <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          res_valid_q <= 1'b1;
          out_valid_q <= result_ready_q;
          out_re_q    <= result_ready_q ? rs_rdata[2*DATA_W-1:DATA_W] : '0;
          out_im_q    <= result_ready_q ? rs_rdata[DATA_W-1:0] : '0;
          frame_end_q <= result_ready_q && frame_done_q;
          if (frame_done_q) begin
            cnt_q   <= '0;
            state_q <= ST_COPY;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_COPY: begin
          // load data arrives next cycle and lands at the bit-reversed slot
          pend_q      <= 1'b1;
          pend_addr_q <= bit_rev(cnt_q, lg_q);
          if (cnt_q == n_mask) begin
            state_q <= ST_COPY_END;
          end else begin
            cnt_q <= cnt_q + AW'(1);
          end
        end
        ST_COPY_END: begin
          bi_q    <= '0;
          stage_q <= '0;
          if (lg_q == '0) begin
            result_ready_q <= 1'b1;
            state_q        <= ST_IDLE;
          end else begin
            state_q <= ST_BF_RDA;
          end
        end
        ST_BF_RDA: begin
          wr_q    <= tw_neg ? -tw_cos : tw_cos;
          wi_q    <= inverse_q ? tw_sin : -tw_sin;
          state_q <= ST_BF_RDB;
        end
        ST_BF_RDB: begin
          a_re_q  <= rs_rdata[2*DATA_W-1:DATA_W];
          a_im_q  <= rs_rdata[DATA_W-1:0];
          state_q <= ST_BF_LDB;
        end
        ST_BF_LDB: begin
          b_re_q  <= rs_rdata[2*DATA_W-1:DATA_W];
          b_im_q  <= rs_rdata[DATA_W-1:0];
          state_q <= ST_BF_MUL0;
        end
        ST_BF_MUL0: begin
          prod_q  <= mul_p;
          state_q <= ST_BF_MUL1;
        end
        ST_BF_MUL1: begin
          acc_q   <= prod_q;
          prod_q  <= mul_p;
          state_q <= ST_BF_MUL2;
        end
        ST_BF_MUL2: begin
          t_re_q  <= t_rnd[T_W-1:0];
          prod_q  <= mul_p;
          state_q <= ST_BF_MUL3;
        end
        ST_BF_MUL3: begin
          acc_q   <= prod_q;
          prod_q  <= mul_p;
          state_q <= ST_BF_RND;
        end
        ST_BF_RND: begin
          t_im_q  <= t_rnd[T_W-1:0];
          state_q <= ST_BF_WRA;
        end
        ST_BF_WRA: begin
          state_q <= ST_BF_WRB;
        end
        ST_BF_WRB: begin
          if (!bf_last) begin
            bi_q    <= bi_q + AW'(1);
            state_q <= ST_BF_RDA;
          end else begin
            bi_q <= '0;
            if (!stage_last) begin
              stage_q <= stage_q + LOG2_W'(1);
              state_q <= ST_BF_RDA;
            end else if (inverse_q) begin
              cnt_q   <= '0;
              state_q <= ST_SC_RD;
            end else begin
              result_ready_q <= 1'b1;
              state_q        <= ST_IDLE;
            end
          end
        end
        ST_SC_RD: begin
          state_q <= ST_SC_WR;
        end
        ST_SC_WR: begin
          if (cnt_q == n_mask) begin
            result_ready_q <= 1'b1;
            state_q        <= ST_IDLE;
          end else begin
            cnt_q   <= cnt_q + AW'(1);
            state_q <= ST_SC_RD;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign res_valid_o = res_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_re_o    = out_re_q;
  assign out_im_o    = out_im_q;
  assign frame_end_o = frame_end_q;

`ifndef NO_ASSERTIONS
  a_accept_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ST_FETCH)
    else $error("accepted transaction did not move to fetch");

  a_count_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q & ~n_mask) == '0)
    else $error("load count beyond frame size");

  a_stage_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_BF_RDA |-> stage_q < lg_q)
    else $error("butterfly stage beyond transform size");

  a_copy_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == ST_COPY || state_q == ST_COPY_END))
    else $error("copy write outside copy pass");
`endif

endmodule

/* rtl/core/fft_ram.sv */
// generic single write port ram with registered read
module fft_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* tb/sv/testbench.sv */
// self-checking testbench for the radix-2 complex fft core
`timescale 1ns / 100ps

module testbench;
  import fft_pkg::*;

  localparam int WATCHDOG_LIMIT = 400000;

  typedef struct {
    logic              vld;
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic              fe;
  } bin_t;

  typedef struct {
    logic signed [15:0] re;
    logic signed [15:0] im;
    bin_t               bin;
  } row_t;

  typedef struct {
    bit write_size;
    int size_code;
    bit inv;
    int frames;
  } phase_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic signed [SAMPLE_W-1:0] sample_re_i = '0;
  logic signed [SAMPLE_W-1:0] sample_im_i = '0;
  logic                       res_valid_o;
  logic                       res_stall_i = 1'b0;
  logic                       out_valid_o;
  logic signed [DATA_W-1:0]   out_re_o;
  logic signed [DATA_W-1:0]   out_im_o;
  logic                       frame_end_o;
  logic                       cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index_i = '0;
  logic [CFG_W-1:0]           cfg_data_i = '0;

  radix2_complex_fft_core uut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // predictor state
  int   tw_cos [TW_COUNT];
  int   tw_sin [TW_COUNT];
  int   load_re [MAX_POINTS];
  int   load_im [MAX_POINTS];
  int   spec_re [MAX_POINTS];
  int   spec_im [MAX_POINTS];
  int unsigned fill_count;
  bit   spec_ready;
  int unsigned size_log2;
  bit   inverse;

  bin_t bins_expected [$];
  int   mismatches;
  int   send_gap_pct;
  int   stall_pct;
  int   quiet_cycles;

  function automatic longint unsigned q30_to_q15(longint unsigned q);
    longint unsigned v;
    v = (q + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    return (v > (64'd1 << FRAC_BITS) - 1) ? (64'd1 << FRAC_BITS) - 1 : v;
  endfunction

  // taylor sin and cos in q30 for angles in the first octant
  function automatic void octant_q30(input longint unsigned r,
                                     output longint unsigned s, output longint unsigned c);
    longint unsigned sdiv [5] = '{110, 72, 42, 20, 6};
    longint unsigned cdiv [6] = '{132, 90, 56, 30, 12, 2};
    longint unsigned x, x2, t;
    x  = (r * 64'd3373259426 + 64'd32768) >> 16;
    x2 = (x * x + (64'd1 << 29)) >> 30;
    t = 64'd1 << 30;
    foreach (sdiv[i]) t = (64'd1 << 30) - ((x2 * t) >> 30) / sdiv[i];
    s = (x * t) >> 30;
    t = 64'd1 << 30;
    foreach (cdiv[i]) t = (64'd1 << 30) - ((x2 * t) >> 30) / cdiv[i];
    c = t;
  endfunction

  function automatic void build_twiddles();
    longint unsigned p, s, c;
    bit flip;
    for (int j = 0; j < TW_COUNT; j++) begin
      p = longint'(j) << (17 - MAX_LOG2_POINTS);
      flip = 1'b0;
      if (p > 32768) begin
        p = 65536 - p;
        flip = 1'b1;
      end
      if (p > 16384) octant_q30(32768 - p, c, s);
      else octant_q30(p, s, c);
      tw_cos[j] = flip ? -int'(q30_to_q15(c)) : int'(q30_to_q15(c));
      tw_sin[j] = int'(q30_to_q15(s));
    end
  endfunction

  function automatic longint round_down(longint v, int sh);
    if (sh == 0) return v;
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic int clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  function automatic void compute_spectrum();
    int unsigned n, rj, col, b, twi;
    longint wr, wi, br, bi, tr, tim, ar, ai;
    n = 1 << size_log2;
    for (int unsigned i = 0; i < n; i++) begin
      rj = 0;
      for (int unsigned k = 0; k < size_log2; k++) rj |= ((i >> k) & 1) << (size_log2 - 1 - k);
      spec_re[rj] = load_re[i];
      spec_im[rj] = load_im[i];
    end
    for (int unsigned s = 0; s < size_log2; s++) begin
      col = 1 << s;
      for (int unsigned m = 0; m < col; m++) begin
        twi = m << (MAX_LOG2_POINTS - 1 - s);
        wr = tw_cos[twi];
        wi = inverse ? longint'(tw_sin[twi]) : -longint'(tw_sin[twi]);
        for (int unsigned k = m; k < n; k += 2 * col) begin
          b = k + col;
          br = spec_re[b];
          bi = spec_im[b];
          tr  = round_down(wr * br - wi * bi, FRAC_BITS);
          tim = round_down(wi * br + wr * bi, FRAC_BITS);
          ar = spec_re[k];
          ai = spec_im[k];
          spec_re[b] = clip32(ar - tr);
          spec_im[b] = clip32(ai - tim);
          spec_re[k] = clip32(ar + tr);
          spec_im[k] = clip32(ai + tim);
        end
      end
    end
    if (inverse) begin
      for (int unsigned i = 0; i < n; i++) begin
        spec_re[i] = int'(round_down(spec_re[i], size_log2));
        spec_im[i] = int'(round_down(spec_im[i], size_log2));
      end
    end
  endfunction

  function automatic bin_t predict_bin(logic signed [15:0] re, logic signed [15:0] im);
    bin_t o;
    int unsigned n, idx;
    n = 1 << size_log2;
    idx = fill_count & (n - 1);
    o = '{1'b0, 32'sd0, 32'sd0, 1'b0};
    if (spec_ready) o = '{1'b1, spec_re[idx], spec_im[idx], idx == n - 1};
    load_re[idx] = re;
    load_im[idx] = im;
    fill_count = idx + 1;
    if (fill_count >= n) begin
      compute_spectrum();
      spec_ready = 1'b1;
      fill_count = 0;
    end
    return o;
  endfunction

  // transaction on the input channel; returns once accepted
  task automatic send_sample(logic signed [15:0] re, logic signed [15:0] im, bit typed,
                             bin_t typed_bin);
    int gap;
    bin_t p;
    gap = 0;
    while (gap < 60 && $urandom_range(99) < send_gap_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_re_i <= re;
    sample_im_i <= im;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    p = predict_bin(re, im);
    bins_expected.push_back(typed ? typed_bin : p);
  endtask

  // wait for the last result, then for the transform that may still run
  task automatic settle();
    int unsigned n;
    in_valid_i <= 1'b0;
    while (bins_expected.size() != 0) @(posedge clk_i);
    n = 1 << size_log2;
    repeat (n + 2 + 5 * n * size_log2 + 2 * n + 50) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val[CFG_W-1:0];
    @(posedge clk_i);
    if (idx == CFG_LOG2_POINTS) begin
      size_log2 = (val > MAX_LOG2_POINTS) ? MAX_LOG2_POINTS : val;
      fill_count = 0;
      spec_ready = 1'b0;
    end else begin
      inverse = val[0];
    end
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(7))
      0: return $urandom_range(1) ? 16'h7fff : 16'h8000;
      1: return 16'($signed($urandom_range(64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  // size 0: each sample comes back unchanged on the next transaction
  row_t directed [] = '{
    '{16'sd0,      16'sd0,      '{1'b0, 32'sd0,      32'sd0,      1'b0}},
    '{16'sh7fff,   16'sh8000,   '{1'b1, 32'sd0,      32'sd0,      1'b1}},
    '{16'sh8000,   16'sh7fff,   '{1'b1, 32'sd32767,  -32'sd32768, 1'b1}},
    '{-16'sd1,     16'sd1,      '{1'b1, -32'sd32768, 32'sd32767,  1'b1}},
    '{16'sd1,      -16'sd1,     '{1'b1, -32'sd1,     32'sd1,      1'b1}},
    '{16'sh5555,   16'shaaaa,   '{1'b1, 32'sd1,      -32'sd1,     1'b1}},
    '{16'shaaaa,   16'sh5555,   '{1'b1, 32'sd21845,  -32'sd21846, 1'b1}},
    '{16'sh7fff,   16'sh7fff,   '{1'b1, -32'sd21846, 32'sd21845,  1'b1}},
    '{16'sh8000,   16'sh8000,   '{1'b1, 32'sd32767,  32'sd32767,  1'b1}},
    '{16'sd0,      16'sd0,      '{1'b1, -32'sd32768, -32'sd32768, 1'b1}}
  };

  phase_t phases [] = '{
    '{1'b1, 1, 1'b0, 6},
    '{1'b1, 2, 1'b1, 6},
    '{1'b0, 2, 1'b0, 6},
    '{1'b1, 3, 1'b0, 5},
    '{1'b1, 4, 1'b1, 4},
    '{1'b1, 5, 1'b0, 3},
    '{1'b1, 6, 1'b1, 2},
    '{1'b1, 8, 1'b0, 2},
    '{1'b1, 0, 1'b1, 20},
    '{1'b1, 15, 1'b0, 1},
    '{1'b1, 3, 1'b1, 4}
  };

  initial begin
    bin_t none;
    int items;
    none = '{1'b0, 32'sd0, 32'sd0, 1'b0};
    mismatches = 0;
    send_gap_pct = 0;
    stall_pct = 0;
    build_twiddles();
    foreach (load_re[i]) begin
      load_re[i] = 0;
      load_im[i] = 0;
      spec_re[i] = 0;
      spec_im[i] = 0;
    end
    fill_count = 0;
    spec_ready = 1'b0;
    size_log2 = LG_RESET;
    inverse = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(CFG_LOG2_POINTS, 0);
    write_reg(CFG_INVERSE_MODE, 0);
    cfg_we_i <= 1'b0;
    foreach (directed[i]) send_sample(directed[i].re, directed[i].im, 1'b1, directed[i].bin);
    settle();

    foreach (phases[k]) begin
      case (k % 4)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 86; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 86; end
        default: begin send_gap_pct = 24; stall_pct = 24; end
      endcase
      if (phases[k].write_size) write_reg(CFG_LOG2_POINTS, phases[k].size_code);
      write_reg(CFG_INVERSE_MODE, phases[k].inv);
      cfg_we_i <= 1'b0;
      items = phases[k].frames << size_log2;
      repeat (items) begin
        send_sample(pick_sample(), pick_sample(), 1'b0, none);
      end
      settle();
    end

    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // result channel: compare and draw the next stall
  always @(posedge clk_i) begin
    bin_t e;
    if (rst_ni && res_valid_o && !res_stall_i) begin
      if (bins_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result re=%0d im=%0d", out_re_o, out_im_o);
      end else begin
        e = bins_expected.pop_front();
        if (out_valid_o !== e.vld || out_re_o !== e.re || out_im_o !== e.im
            || frame_end_o !== e.fe) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp v=%0b re=%0d im=%0d end=%0b, got v=%0b re=%0d im=%0d end=%0b",
                     e.vld, e.re, e.im, e.fe, out_valid_o, out_re_o, out_im_o, frame_end_o);
        end
      end
    end
    res_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (res_valid_o && !res_stall_i) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
